/* src/sgcig_pkg.sv */
package sgcig_pkg;

  localparam int MAX_DIMS_DEF = 6;
  localparam int ID_BITS_DEF  = 62;
  // working width for a packed id, covers the widest dims * level span (66 bits)
  localparam int XW           = 72;
  localparam int LIM_W        = 6;
  localparam int ND_W         = 3;
  localparam int LIMITS_W     = 36;
  localparam int CFG_DW       = 64;
  localparam int CFG_AW       = 5;

  typedef enum logic [1:0] {
    REG_LEVEL_CAP = 2'd0,
    REG_NUM_DIMS  = 2'd1,
    REG_ADAPT_EN  = 2'd2,
    REG_ADAPT_LIM = 2'd3
  } reg_idx_t;

  // widest level that still packs for a given dimension count
  function automatic logic [LIM_W-1:0] bound_for(input logic [ND_W-1:0] nd);
    logic [LIM_W-1:0] b;
    case (nd)
      3'd0, 3'd1: b = 6'd62;
      3'd2:       b = 6'd33;
      3'd3:       b = 6'd20;
      3'd4:       b = 6'd16;
      3'd5:       b = 6'd13;
      default:    b = 6'd9;
    endcase
    return b;
  endfunction

  // position of the leading one among bits 62:0 plus one, zero for zero
  function automatic logic [LIM_W-1:0] level_of(input logic [63:0] v);
    logic [LIM_W-1:0] lev;
    lev = '0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) lev = LIM_W'(i + 1);
    end
    return lev;
  endfunction

endpackage

/* src/sparse_grid_child_id_generator.sv */
// flow: the start transfer is loaded into the item register, the first child is then picked
//   and registered into the result register, then one child follows per cycle
// throughput: an item occupies the emitter until its children are picked; the next item is
//   taken in the cycle its predecessor's last child is picked, childless items every cycle
// results cannot be stalled: each child is shown for exactly one cycle on out_valid
// reset: synchronous, clears the emitter and restores the configuration defaults
module sparse_grid_child_id_generator #(
  parameter int MAX_DIMS = sgcig_pkg::MAX_DIMS_DEF,
  parameter int ID_BITS  = sgcig_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ID_BITS-1:0]           in_element_id,
  output logic                         out_valid,
  output logic [ID_BITS-1:0]           out_child_id,
  output logic [2:0]                   out_child_dim,
  output logic                         out_second_child,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sgcig_pkg::CFG_AW-1:0] paddr,
  input  logic [sgcig_pkg::CFG_DW-1:0] pwdata,
  output logic [sgcig_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);
  import sgcig_pkg::*;

  localparam int NCH = 2 * MAX_DIMS;

  // configuration registers
  logic [LIM_W-1:0]    level_cap_r;
  logic [ND_W-1:0]     num_dims_r;
  logic                adapt_en_r;
  logic [LIMITS_W-1:0] adapt_lim_r;

  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic [LIM_W-1:0]    ml_bound;
  logic [LIM_W-1:0]    ml_wr;
  logic [ND_W-1:0]     nd_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:3]);

  always_comb begin
    ml_bound = bound_for(num_dims_r);
    ml_wr    = pwdata[LIM_W-1:0];
    if (ml_wr == '0) ml_wr = LIM_W'(1);
    if (ml_wr > ml_bound) ml_wr = ml_bound;
    nd_wr = pwdata[ND_W-1:0];
    if (nd_wr == '0) nd_wr = ND_W'(1);
    if (nd_wr > ND_W'(MAX_DIMS)) nd_wr = ND_W'(MAX_DIMS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_cap_r <= LIM_W'(4);
      num_dims_r  <= ND_W'(1);
      adapt_en_r  <= 1'b0;
      adapt_lim_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LEVEL_CAP: level_cap_r <= ml_wr;
        REG_NUM_DIMS:  num_dims_r  <= nd_wr;
        REG_ADAPT_EN:  adapt_en_r  <= pwdata[0];
        REG_ADAPT_LIM: adapt_lim_r <= pwdata[LIMITS_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LEVEL_CAP: prdata = CFG_DW'(level_cap_r);
      REG_NUM_DIMS:  prdata = CFG_DW'(num_dims_r);
      REG_ADAPT_EN:  prdata = CFG_DW'(adapt_en_r);
      REG_ADAPT_LIM: prdata = CFG_DW'(adapt_lim_r);
      default:       prdata = '0;
    endcase
  end

  // item register and emitter state
  logic [ID_BITS-1:0] id_r;
  logic               act_r;
  logic [NCH-1:0]     done_r;

  // field width, a stale level cap is held to the bound of the current dimension count
  logic [LIM_W-1:0] w;
  logic [8:0]       span;
  logic [XW-1:0]    wmask;
  logic [XW-1:0]    id_wide;
  logic [XW-1:0]    base;

  always_comb begin
    w = level_cap_r;
    if (w > bound_for(num_dims_r)) w = bound_for(num_dims_r);
    if (w == '0) w = LIM_W'(1);
    span    = 9'(num_dims_r) * 9'(w);
    wmask   = (XW'(1) << w) - XW'(1);
    id_wide = XW'(id_r);
    base    = id_wide & ((XW'(1) << span) - XW'(1));
  end

  // per-dimension decode
  logic [NCH-1:0] kids;
  logic [XW-1:0]  fclr   [MAX_DIMS];
  logic [XW-1:0]  field0 [MAX_DIMS];
  logic [XW-1:0]  field1 [MAX_DIMS];

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
    logic [8:0]       sh;
    logic [63:0]      v;
    logic [LIM_W-1:0] lev;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] alim;
    logic [63:0]      cval;
    logic             ok;

    always_comb begin
      sh   = 9'(d) * 9'(w);
      v    = 64'((id_wide >> sh) & wmask);
      lev  = level_of(v);
      alim = adapt_lim_r[LIM_W*d +: LIM_W];
      lim  = w;
      if (adapt_en_r && (alim < lim)) lim = alim;
      ok   = (ND_W'(d) < num_dims_r) && ((7'(lev) + 7'd1) <= 7'(lim));
      cval = (v == '0) ? 64'd1 : (v << 1);
      kids[2*d]     = ok;
      kids[2*d + 1] = ok && (lev != '0);
      fclr[d]       = wmask << sh;
      field0[d]     = XW'(cval) << sh;
      field1[d]     = XW'(cval | 64'd1) << sh;
    end
  end

  // pick the lowest outstanding child
  logic [NCH-1:0] pending;
  logic [NCH-1:0] pick_oh;
  logic           more;
  logic           accept;
  logic [XW-1:0]  child;
  logic [2:0]     child_dim;
  logic           child_second;

  always_comb begin
    pending      = act_r ? (kids & ~done_r) : '0;
    pick_oh      = pending & (~pending + NCH'(1));
    more         = |(pending & (pending - NCH'(1)));
    child        = base;
    child_dim    = '0;
    child_second = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (pick_oh[2*d]) begin
        child     = (base & ~fclr[d]) | field0[d];
        child_dim = 3'(d);
      end
      if (pick_oh[2*d + 1]) begin
        child        = (base & ~fclr[d]) | field1[d];
        child_dim    = 3'(d);
        child_second = 1'b1;
      end
    end
  end

  assign busy   = more;
  assign accept = start & ~more;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= '0;
    end else if (accept) begin
      act_r  <= 1'b1;
      done_r <= '0;
    end else begin
      done_r <= done_r | pick_oh;
      if (!more) act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) id_r <= in_element_id;
  end

  // result register
  logic               out_valid_r;
  logic [ID_BITS-1:0] out_child_id_r;
  logic [2:0]         out_child_dim_r;
  logic               out_second_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= |pending;
    end
  end

  always_ff @(posedge clk) begin
    out_child_id_r  <= child[ID_BITS-1:0];
    out_child_dim_r <= child_dim;
    out_second_r    <= child_second;
    out_last_r      <= ~more;
  end

  assign out_valid        = out_valid_r;
  assign out_child_id     = out_child_id_r;
  assign out_child_dim    = out_child_dim_r;
  assign out_second_child = out_second_r;
  assign out_last         = out_last_r;

endmodule

/* src/sgcig_checker.sv */
module sgcig_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_child_dim,
  input logic       out_second_child,
  input logic       out_last
);

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result transfer right after reset");

  // a second child directly follows the first child of the same dimension
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_child |->
      $past(out_valid) && !$past(out_second_child) && !$past(out_last) &&
      ($past(out_child_dim) == out_child_dim))
    else $error("second child without its first child");

  // children of one item come in an unbroken run
  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a run of children");

  // more children pending means the block was refusing new items
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> $past(busy))
    else $error("new item could be taken while children were pending");

endmodule

bind sparse_grid_child_id_generator sgcig_checker u_sgcig_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_child_dim    (out_child_dim),
  .out_second_child (out_second_child),
  .out_last         (out_last)
);
